FILE: design/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared sizes, types and state codes of the LRU page replacement unit.
// ----------------------------------------------------------------------------
package lpr_pkg;

    localparam int NUM_PAGES  = 16;
    localparam int MAX_FRAMES = 8;
    localparam int PAGE_W     = 4;
    localparam int FRAME_W    = 3;
    localparam int RANK_W     = 3;
    localparam int LIMIT_W    = 4;
    localparam int CNT_W      = 16;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(MAX_FRAMES);
    localparam logic [CNT_W-1:0]   CNT_MAX     = {CNT_W{1'b1}};

    typedef logic [PAGE_W-1:0]  page_t;
    typedef logic [FRAME_W-1:0] frame_t;
    typedef logic [RANK_W-1:0]  rank_t;
    typedef logic [CNT_W-1:0]   cnt_t;

    // one-hot sequencer codes
    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_LOOKUP = 2'b10
    } state_t;

endpackage

FILE: design/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// lru_page_replacement
// Page reference unit with a page table, frame owners and true LRU order.
// ----------------------------------------------------------------------------
// Each request carries one page number. A resident page hits and its frame
// becomes most recently used; otherwise a fault is counted and the page goes
// to the lowest vacant frame below the frame limit, or, if none is vacant,
// replaces the least recently used page below the limit, which is reported.
// Hit and fault counts saturate at 65535. A request first gets the registered
// read of the page-to-frame RAM, then a resolve step that settles hit, vacancy
// and victim and writes the state back; the next request is taken only once
// the result is registered, so no new request enters before the last is done.
// If the output register is still full, the resolve step waits for it. No
// clearing pass after reset: residency and occupancy live in flip-flops. The
// frame limit register (0 acts as 1, above 8 acts as 8) is to be written only
// while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module lru_page_replacement (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration write channel
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [lpr_pkg::LIMIT_W-1:0] cfg_data,
    // request channel
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [lpr_pkg::PAGE_W-1:0]  page_number,
    // result channel
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        hit,
    output logic [lpr_pkg::FRAME_W-1:0] frame_index,
    output logic                        evicted,
    output logic [lpr_pkg::PAGE_W-1:0]  evicted_page,
    output logic [lpr_pkg::CNT_W-1:0]   fault_count,
    output logic [lpr_pkg::CNT_W-1:0]   hit_count
);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    lpr_pkg::state_t state_reg, state_next;
    logic [lpr_pkg::LIMIT_W-1:0] limit_reg;

    logic [lpr_pkg::NUM_PAGES-1:0]  page_resident_reg, page_resident_next;
    logic [lpr_pkg::MAX_FRAMES-1:0] frame_occupied_reg, frame_occupied_next;
    lpr_pkg::page_t frame_owner_reg [lpr_pkg::MAX_FRAMES];
    lpr_pkg::page_t frame_owner_next [lpr_pkg::MAX_FRAMES];
    lpr_pkg::rank_t rank_reg [lpr_pkg::MAX_FRAMES];
    lpr_pkg::rank_t rank_next [lpr_pkg::MAX_FRAMES];
    lpr_pkg::cnt_t  fault_cnt_reg, fault_cnt_next;
    lpr_pkg::cnt_t  hit_cnt_reg, hit_cnt_next;

    lpr_pkg::page_t page_reg;

    // output register
    logic           out_valid_reg, out_valid_next;
    logic           hit_out_reg;
    lpr_pkg::frame_t frame_out_reg;
    logic           evicted_out_reg;
    lpr_pkg::page_t evicted_page_out_reg;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic accept;
    logic commit;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == lpr_pkg::ST_IDLE);
    assign accept    = in_valid && in_ready;
    // resolve step fires once the output register can take the result
    assign commit    = (state_reg == lpr_pkg::ST_LOOKUP) && (!out_valid_reg || out_ready);

    // ------------------------------------------------------------------
    // Page-to-frame table: read on accept, written back on a fault
    // ------------------------------------------------------------------
    lpr_pkg::frame_t pf_rdata;
    logic            pf_we;
    lpr_pkg::frame_t sel_frame;

    lpr_ram #(
        .WIDTH (lpr_pkg::FRAME_W),
        .DEPTH (lpr_pkg::NUM_PAGES)
    ) u_page_frame (
        .clk   (clk),
        .we    (pf_we),
        .waddr (page_reg),
        .wdata (sel_frame),
        .re    (accept),
        .raddr (page_number),
        .rdata (pf_rdata)
    );

    // ------------------------------------------------------------------
    // Resolve: hit, vacancy, victim, recency update
    // ------------------------------------------------------------------
    logic [lpr_pkg::LIMIT_W-1:0]    limit_eff;
    logic [lpr_pkg::MAX_FRAMES-1:0] in_window;
    logic [lpr_pkg::MAX_FRAMES-1:0] vacant;
    logic                           is_hit;
    logic                           has_vacant;
    logic                           do_evict;
    lpr_pkg::frame_t                vac_frame;
    lpr_pkg::frame_t                victim;
    lpr_pkg::rank_t                 best_rank;
    lpr_pkg::rank_t                 sel_rank;
    lpr_pkg::page_t                 ev_page;

    always_comb
    begin
        // clamp frame limit to 1..MAX_FRAMES
        if (limit_reg == '0)
        begin
            limit_eff = lpr_pkg::LIMIT_W'(1);
        end
        else if (limit_reg > lpr_pkg::LIMIT_W'(lpr_pkg::MAX_FRAMES))
        begin
            limit_eff = lpr_pkg::LIMIT_W'(lpr_pkg::MAX_FRAMES);
        end
        else
        begin
            limit_eff = limit_reg;
        end

        for (int k = 0; k < lpr_pkg::MAX_FRAMES; k++)
        begin
            in_window[k] = (lpr_pkg::LIMIT_W'(k) < limit_eff);
        end
        vacant     = in_window & ~frame_occupied_reg;
        has_vacant = |vacant;

        // lowest vacant frame
        vac_frame = '0;
        for (int k = lpr_pkg::MAX_FRAMES - 1; k >= 0; k--)
        begin
            if (vacant[k])
            begin
                vac_frame = lpr_pkg::FRAME_W'(k);
            end
        end

        // oldest frame in window; lowest index wins a tie
        victim    = '0;
        best_rank = '0;
        for (int k = 0; k < lpr_pkg::MAX_FRAMES; k++)
        begin
            if (in_window[k] && (rank_reg[k] > best_rank))
            begin
                best_rank = rank_reg[k];
                victim    = lpr_pkg::FRAME_W'(k);
            end
        end

        is_hit   = page_resident_reg[page_reg];
        do_evict = !is_hit && !has_vacant;

        if (is_hit)
        begin
            sel_frame = pf_rdata;
        end
        else if (has_vacant)
        begin
            sel_frame = vac_frame;
        end
        else
        begin
            sel_frame = victim;
        end
        sel_rank = rank_reg[sel_frame];
        ev_page  = do_evict ? frame_owner_reg[victim] : '0;

        pf_we = commit && !is_hit;

        // defaults: hold
        state_next          = state_reg;
        page_resident_next  = page_resident_reg;
        frame_occupied_next = frame_occupied_reg;
        fault_cnt_next      = fault_cnt_reg;
        hit_cnt_next        = hit_cnt_reg;
        for (int k = 0; k < lpr_pkg::MAX_FRAMES; k++)
        begin
            frame_owner_next[k] = frame_owner_reg[k];
            rank_next[k]        = rank_reg[k];
        end

        unique case (state_reg)
            lpr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = lpr_pkg::ST_LOOKUP;
                end
            end
            lpr_pkg::ST_LOOKUP:
            begin
                if (commit)
                begin
                    state_next = lpr_pkg::ST_IDLE;

                    // frames newer than the touched one age by one;
                    // a fill into a vacant frame ages every occupied frame
                    for (int k = 0; k < lpr_pkg::MAX_FRAMES; k++)
                    begin
                        if ((lpr_pkg::FRAME_W'(k) != sel_frame) && frame_occupied_reg[k]
                            && ((!is_hit && has_vacant) || (rank_reg[k] < sel_rank)))
                        begin
                            rank_next[k] = rank_reg[k] + lpr_pkg::RANK_W'(1);
                        end
                    end
                    rank_next[sel_frame] = '0;

                    if (is_hit)
                    begin
                        if (hit_cnt_reg != lpr_pkg::CNT_MAX)
                        begin
                            hit_cnt_next = hit_cnt_reg + lpr_pkg::CNT_W'(1);
                        end
                    end
                    else
                    begin
                        if (fault_cnt_reg != lpr_pkg::CNT_MAX)
                        begin
                            fault_cnt_next = fault_cnt_reg + lpr_pkg::CNT_W'(1);
                        end
                        if (do_evict)
                        begin
                            page_resident_next[ev_page] = 1'b0;
                        end
                        page_resident_next[page_reg]   = 1'b1;
                        frame_occupied_next[sel_frame] = 1'b1;
                        frame_owner_next[sel_frame]    = page_reg;
                    end
                end
            end
            default:
            begin
                state_next = lpr_pkg::ST_IDLE;
            end
        endcase

        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Registers with reset
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= lpr_pkg::ST_IDLE;
            limit_reg          <= lpr_pkg::LIMIT_RESET;
            page_resident_reg  <= '0;
            frame_occupied_reg <= '0;
            fault_cnt_reg      <= '0;
            hit_cnt_reg        <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            page_resident_reg  <= page_resident_next;
            frame_occupied_reg <= frame_occupied_next;
            fault_cnt_reg      <= fault_cnt_next;
            hit_cnt_reg        <= hit_cnt_next;
            out_valid_reg      <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers (no reset)
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            page_reg <= page_number;
        end
        for (int k = 0; k < lpr_pkg::MAX_FRAMES; k++)
        begin
            frame_owner_reg[k] <= frame_owner_next[k];
            rank_reg[k]        <= rank_next[k];
        end
        if (commit)
        begin
            hit_out_reg          <= is_hit;
            frame_out_reg        <= sel_frame;
            evicted_out_reg      <= do_evict;
            evicted_page_out_reg <= ev_page;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit          = hit_out_reg;
    assign frame_index  = frame_out_reg;
    assign evicted      = evicted_out_reg;
    assign evicted_page = evicted_page_out_reg;
    assign fault_count  = fault_cnt_reg;
    assign hit_count    = hit_cnt_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // every resident page owns exactly one occupied frame
    a_resident_matches_occupied: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(page_resident_reg) == $countones(frame_occupied_reg))
        else $error("resident page count differs from occupied frame count");

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(hit_out_reg && evicted_out_reg))
        else $error("result reports both hit and eviction");

    // the reported frame is occupied
    a_frame_occupied: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> frame_occupied_reg[frame_out_reg])
        else $error("result frame is not occupied");

    // an accepted request moves to the lookup state in the next cycle
    a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == lpr_pkg::ST_LOOKUP))
        else $error("accepted request did not enter lookup");

endmodule

FILE: design/lpr_ram.sv
// ----------------------------------------------------------------------------
// lpr_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module lpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LRU page replacement unit.
// ----------------------------------------------------------------------------
// Page references go in over a valid/ready request channel. A shadow page
// table, frame owner map and LRU rank set in this file predict each result,
// and a monitor checks every result field against the oldest prediction.
// Directed requests cover table fill, LRU eviction after a hit, frame limit
// extremes and a limit lowered under loaded frames. Random locality traffic
// then runs under four idling mixes.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT = 2_000_000;

    // one result as the block should report it
    typedef struct {
        logic            hit;
        lpr_pkg::frame_t frame;
        logic            evicted;
        lpr_pkg::page_t  ev_page;
        lpr_pkg::cnt_t   faults;
        lpr_pkg::cnt_t   hits;
    } ref_result_t;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [lpr_pkg::LIMIT_W-1:0]  cfg_data;
    logic                         in_valid;
    logic                         in_ready;
    lpr_pkg::page_t               page_number;
    logic                         out_valid;
    logic                         out_ready;
    logic                         hit;
    lpr_pkg::frame_t              frame_index;
    logic                         evicted;
    lpr_pkg::page_t               evicted_page;
    lpr_pkg::cnt_t                fault_count;
    lpr_pkg::cnt_t                hit_count;

    lru_page_replacement uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .page_number  (page_number),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit          (hit),
        .frame_index  (frame_index),
        .evicted      (evicted),
        .evicted_page (evicted_page),
        .fault_count  (fault_count),
        .hit_count    (hit_count)
    );

    // ------------------------------------------------------------------------
    // Shadow state of the unit. Only the entries of resident pages and
    // occupied frames are ever read.
    // ------------------------------------------------------------------------
    bit                          page_is_resident [lpr_pkg::NUM_PAGES];
    lpr_pkg::frame_t             page_to_frame    [lpr_pkg::NUM_PAGES];
    lpr_pkg::page_t              frame_to_page    [lpr_pkg::MAX_FRAMES];
    bit                          frame_in_use     [lpr_pkg::MAX_FRAMES];
    int                          frame_age        [lpr_pkg::MAX_FRAMES];   // 0 = most recent
    lpr_pkg::cnt_t               fault_tally;
    lpr_pkg::cnt_t               hit_tally;
    logic [lpr_pkg::LIMIT_W-1:0] frame_limit;

    ref_result_t        pending_results[$];
    int                 mismatches;
    int                 send_gap_pct;    // chance per cycle the sender idles
    int                 sink_stall_pct;  // chance per cycle the sink stalls
    bit                 ref_held;        // in_valid is currently driven high

    // Make frame f the most recent; frames younger than old_age get older.
    function automatic void refresh_frame(int f, int old_age);
        for (int k = 0; k < lpr_pkg::MAX_FRAMES; k++)
        begin
            if (k != f && frame_in_use[k] && frame_age[k] < old_age)
                frame_age[k]++;
        end
        frame_age[f] = 0;
    endfunction

    // Work out the result of one page reference and update the shadow state.
    function automatic ref_result_t lru_predict(lpr_pkg::page_t pg);
        ref_result_t r;
        int          lim;
        int          f;
        int          best;
        bit          found;

        // out-of-range limits clamp: 0 behaves as 1, anything above 8 as 8
        lim = int'(frame_limit);
        if (lim == 0)
            lim = 1;
        if (lim > lpr_pkg::MAX_FRAMES)
            lim = lpr_pkg::MAX_FRAMES;

        r.hit     = 1'b0;
        r.evicted = 1'b0;
        r.ev_page = '0;
        f         = 0;

        if (page_is_resident[pg])
        begin
            // pages in frames above a lowered limit still hit
            r.hit = 1'b1;
            f     = int'(page_to_frame[pg]);
            refresh_frame(f, frame_age[f]);
            if (hit_tally != lpr_pkg::CNT_MAX)
                hit_tally++;
        end
        else
        begin
            if (fault_tally != lpr_pkg::CNT_MAX)
                fault_tally++;
            found = 1'b0;
            for (int k = 0; k < lim; k++)
            begin
                if (!found && !frame_in_use[k])
                begin
                    f     = k;
                    found = 1'b1;
                end
            end
            if (found)
            begin
                frame_in_use[f] = 1'b1;
                refresh_frame(f, lpr_pkg::MAX_FRAMES);   // older than anything: all age
            end
            else
            begin
                // victim is the oldest frame below the limit, lowest on a tie
                best = 0;
                for (int k = 0; k < lim; k++)
                begin
                    if (frame_age[k] > best)
                    begin
                        best = frame_age[k];
                        f    = k;
                    end
                end
                r.evicted = 1'b1;
                r.ev_page = frame_to_page[f];
                page_is_resident[frame_to_page[f]] = 1'b0;
                refresh_frame(f, frame_age[f]);
            end
            frame_to_page[f]  = pg;
            page_to_frame[pg] = lpr_pkg::frame_t'(f);
            page_is_resident[pg] = 1'b1;
        end

        r.frame  = lpr_pkg::frame_t'(f);
        r.faults = fault_tally;
        r.hits   = hit_tally;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Clock, sink back-pressure and watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // out_ready gets one fresh random draw per cycle
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result monitor: every accepted result against the oldest prediction
    // ------------------------------------------------------------------------
    function automatic void check_field(string fname, logic [15:0] exp_v,
                                        logic [15:0] act_v);
        if (act_v !== exp_v)
        begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, fname, exp_v, act_v);
        end
    endfunction

    always @(posedge clk)
    begin
        ref_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with no request pending, expected none, got frame %0d",
                         $time, frame_index);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("hit",          16'(want.hit),     16'(hit));
                check_field("frame_index",  16'(want.frame),   16'(frame_index));
                check_field("evicted",      16'(want.evicted), 16'(evicted));
                check_field("evicted_page", 16'(want.ev_page), 16'(evicted_page));
                check_field("fault_count",  want.faults,       fault_count);
                check_field("hit_count",    want.hits,         hit_count);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    // Lower in_valid unless it is already low, so that a signal never gets
    // two assignments in one step.
    task automatic release_ref();
        if (ref_held)
        begin
            in_valid <= 1'b0;
            ref_held  = 1'b0;
        end
    endtask

    // Send one page reference; valid stays high into the next request
    // unless the sender decides to idle first.
    task automatic send_ref(input lpr_pkg::page_t pg);
        if ($urandom_range(99) < send_gap_pct)
        begin
            release_ref();
            do
                @(posedge clk);
            while ($urandom_range(99) < send_gap_pct);
        end
        in_valid    <= 1'b1;
        page_number <= pg;
        ref_held     = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(lru_predict(pg));
    endtask

    // Wait for all results, let the pipe settle, then write the frame limit.
    task automatic write_limit(input logic [lpr_pkg::LIMIT_W-1:0] limit);
        release_ref();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= limit;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        frame_limit = limit;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset limit of 8: fill every frame, hit page 0 so it is not the first
    // victim, then two faults evict in true LRU order (15 first, then 0).
    task automatic test_fill_and_evict();
        lpr_pkg::page_t seq [11] = '{4'd0, 4'd15, 4'd0, 4'd3, 4'd4, 4'd5,
                                     4'd6, 4'd7, 4'd8, 4'd9, 4'd15};
        send_gap_pct   = 0;
        sink_stall_pct = 0;
        foreach (seq[i])
            send_ref(seq[i]);
    endtask

    // Limit lowered under loaded frames, limit 0 (acts as 1), limit 15
    // (acts as 8) and limit 1.
    task automatic test_limit_edges();
        write_limit(4'd2);
        send_ref(4'd7);     // lives in a frame above the limit: still hits
        send_ref(4'd1);     // victim chosen among frames 0 and 1 only
        send_ref(4'd10);
        send_ref(4'd8);     // hits in the top frame
        write_limit(4'd0);
        send_ref(4'd11);    // single usable frame
        send_ref(4'd12);
        send_ref(4'd12);
        write_limit(4'd15);
        send_ref(4'd13);
        send_ref(4'd14);
        write_limit(4'd1);
        send_ref(4'd2);
    endtask

    // Locality traffic: most references come from a small sliding window so
    // that hits, fills and evictions all occur; the rest are uniform noise.
    // Each idling mix runs several chunks with a new frame limit each.
    task automatic test_random_traffic();
        int                          gap_mix   [4] = '{0, 64, 0, 13};
        int                          stall_mix [4] = '{0, 0, 64, 13};
        logic [lpr_pkg::LIMIT_W-1:0] edge_lim  [4] = '{4'd0, 4'd15, 4'd1, 4'd8};
        int                          base;
        int                          span;
        lpr_pkg::page_t              pg;
        for (int mode = 0; mode < 4; mode++)
        begin
            send_gap_pct   = gap_mix[mode];
            sink_stall_pct = stall_mix[mode];
            for (int chunk = 0; chunk < 5; chunk++)
            begin
                if (chunk == 0)
                    write_limit(edge_lim[mode]);
                else
                    write_limit(lpr_pkg::LIMIT_W'($urandom_range(15)));
                base = $urandom_range(15);
                span = $urandom_range(1, 10);
                for (int n = 0; n < 55; n++)
                begin
                    if ($urandom_range(99) < 85)
                        pg = lpr_pkg::page_t'(base + $urandom_range(span - 1));
                    else
                        pg = lpr_pkg::page_t'($urandom_range(15));
                    send_ref(pg);
                    if ($urandom_range(99) < 5)
                        base = $urandom_range(15);   // working set moves
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n       <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        page_number <= '0;
        ref_held       = 1'b0;
        mismatches     = 0;
        send_gap_pct   = 0;
        sink_stall_pct = 0;
        frame_limit    = lpr_pkg::LIMIT_RESET;
        fault_tally    = '0;
        hit_tally      = '0;
        foreach (page_is_resident[i])
            page_is_resident[i] = 1'b0;
        foreach (frame_in_use[i])
        begin
            frame_in_use[i] = 1'b0;
            frame_age[i]    = 0;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_and_evict();
        test_limit_edges();
        test_random_traffic();

        // drain, then give a stray result time to show up
        release_ref();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
